/* hw/rtl/graph_m_coloring_search_unit_defines.svh */
// assertion macros for the colouring search unit
`ifndef GRAPH_M_COLORING_SEARCH_UNIT_DEFINES_SVH
`define GRAPH_M_COLORING_SEARCH_UNIT_DEFINES_SVH

// same-cycle implication
`define GMC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GMC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/gmc_pkg.sv */
package gmc_pkg;

    localparam int VERTICES_DEF   = 8;
    localparam int REPORTED_MAX   = 8;
    localparam int ROW_W          = 8;
    localparam int ID_W           = 3;
    localparam int COLOR_W        = 4;
    localparam int MASK_W         = 1 << COLOR_W;
    localparam logic [COLOR_W-1:0] NUM_COLORS_RST = 4'd3;

    typedef struct packed {
        logic [ID_W-1:0]  row_index;
        logic [ROW_W-1:0] row_bits;
        logic             last_row;
    } t_in_item;

    typedef struct packed {
        logic               found;
        logic [ID_W-1:0]    vertex_id;
        logic [COLOR_W-1:0] vertex_color;
        logic               last;
    } t_out_item;

endpackage

/* hw/rtl/gmc_ram.sv */
module gmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/graph_m_coloring_search_unit.sv */
// channel | direction | handshake                  | payload
// in      | input     | i_in_valid / o_in_ready    | i_in_data  (row_index, row_bits, last_row)
// out     | output    | o_out_valid / i_out_ready  | o_out_data (found, vertex_id, vertex_color, last)
// cfg     | input     | i_cfg_we                   | i_cfg_wdata (num_colors)
//
// a row without the last mark is taken in the idle state, and the unit stays there
// a last row starts a clearing pass over the colour memory, then the search:
// a visit of vertex d reads the colours of vertices 0 to d-1 one per cycle if 0 < d < 8, else none
// the number of visits depends on the graph and num_colors; each result is read, registered
// and held through any output stall; no input transfer is taken until the last result is gone
// i_rst_n is synchronous, active low; it clears the row valid bits and restores num_colors to 3
`include "graph_m_coloring_search_unit_defines.svh"

module graph_m_coloring_search_unit #(
    parameter int VERTICES = gmc_pkg::VERTICES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [gmc_pkg::COLOR_W-1:0]   i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  gmc_pkg::t_in_item             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output gmc_pkg::t_out_item            o_out_data
);

    import gmc_pkg::*;

    localparam int CW        = $clog2(VERTICES);
    localparam int ADJ_DEPTH = (VERTICES < ROW_W) ? VERTICES : ROW_W;
    localparam int ADJ_AW    = $clog2(ADJ_DEPTH);
    localparam int REPORTED  = (VERTICES < REPORTED_MAX) ? VERTICES : REPORTED_MAX;
    localparam int IDX_W     = $clog2(ROW_W) + 1;
    localparam int PIDX_W    = $clog2(ROW_W);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLEAR = 4'd1;
    localparam logic [3:0] S_VISIT = 4'd2;
    localparam logic [3:0] S_LOAD  = 4'd3;
    localparam logic [3:0] S_SWEEP = 4'd4;
    localparam logic [3:0] S_PICK  = 4'd5;
    localparam logic [3:0] S_OREAD = 4'd6;
    localparam logic [3:0] S_OWAIT = 4'd7;
    localparam logic [3:0] S_OHOLD = 4'd8;

    logic [3:0]           r_state, n_state;
    logic [COLOR_W-1:0]   r_num_colors;
    logic [ADJ_DEPTH-1:0] r_adj_vld;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic [CW-1:0]        r_depth, n_depth;
    logic                 r_row_ok, n_row_ok;
    logic [ROW_W-1:0]     r_row, n_row;
    logic [COLOR_W-1:0]   r_cur, n_cur;
    logic [MASK_W-1:0]    r_mask, n_mask;
    logic [IDX_W-1:0]     r_lim, n_lim;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic                 r_pend, n_pend;
    logic [PIDX_W-1:0]    r_pidx, n_pidx;
    t_out_item            r_out, n_out;
    logic                 r_out_valid, n_out_valid;

    logic                 w_in_fire;
    logic                 w_row_in_range;
    logic [ADJ_AW-1:0]    w_adj_waddr;
    logic [ADJ_AW-1:0]    w_adj_raddr;
    logic [ROW_W-1:0]     w_adj_rdata;

    logic                 w_col_we;
    logic [CW-1:0]        w_col_waddr;
    logic [COLOR_W-1:0]   w_col_wdata;
    logic [CW-1:0]        w_col_raddr;
    logic [COLOR_W-1:0]   w_col_rdata;

    logic                 w_pick_ok;
    logic [COLOR_W-1:0]   w_pick_color;

    assign o_in_ready     = (r_state == S_IDLE);
    assign w_in_fire      = i_in_valid && o_in_ready;
    assign w_row_in_range = int'(i_in_data.row_index) < ADJ_DEPTH;
    assign w_adj_waddr    = ADJ_AW'(i_in_data.row_index);
    assign w_adj_raddr    = ADJ_AW'(r_depth);
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out;

    gmc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ADJ_DEPTH)
    ) u_adj_ram (
        .i_clk   (i_clk),
        .i_we    (w_in_fire && w_row_in_range),
        .i_waddr (w_adj_waddr),
        .i_wdata (i_in_data.row_bits),
        .i_raddr (w_adj_raddr),
        .o_rdata (w_adj_rdata)
    );

    gmc_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (VERTICES)
    ) u_col_ram (
        .i_clk   (i_clk),
        .i_we    (w_col_we),
        .i_waddr (w_col_waddr),
        .i_wdata (w_col_wdata),
        .i_raddr (w_col_raddr),
        .o_rdata (w_col_rdata)
    );

    // lowest colour above the current one that no earlier neighbour holds
    always_comb begin
        w_pick_ok    = 1'b0;
        w_pick_color = '0;
        for (int c = MASK_W - 1; c >= 1; c--) begin
            if (COLOR_W'(c) > r_cur && COLOR_W'(c) <= r_num_colors && !r_mask[c]) begin
                w_pick_ok    = 1'b1;
                w_pick_color = COLOR_W'(c);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_depth     = r_depth;
        n_row_ok    = r_row_ok;
        n_row       = r_row;
        n_cur       = r_cur;
        n_mask      = r_mask;
        n_lim       = r_lim;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_pidx      = r_pidx;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        w_col_we    = 1'b0;
        w_col_waddr = r_depth;
        w_col_wdata = '0;
        w_col_raddr = r_depth;

        case (r_state)
            S_IDLE: begin
                if (w_in_fire && i_in_data.last_row) begin
                    n_cnt   = '0;
                    n_state = S_CLEAR;
                end
            end
            S_CLEAR: begin
                w_col_we    = 1'b1;
                w_col_waddr = r_cnt;
                if (r_cnt == CW'(VERTICES - 1)) begin
                    n_depth = '0;
                    n_state = S_VISIT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_VISIT: begin
                w_col_raddr = r_depth;
                n_row_ok    = (int'(r_depth) < ADJ_DEPTH) && r_adj_vld[w_adj_raddr];
                n_lim       = (int'(r_depth) < ADJ_DEPTH) ? IDX_W'(r_depth) : '0;
                n_state     = S_LOAD;
            end
            S_LOAD: begin
                n_row   = r_row_ok ? w_adj_rdata : '0;
                n_cur   = w_col_rdata;
                n_mask  = '0;
                n_idx   = '0;
                n_pend  = 1'b0;
                n_state = S_SWEEP;
            end
            S_SWEEP: begin
                // read one earlier vertex a cycle, fold its colour in on the next cycle
                w_col_raddr = CW'(r_idx);
                if (r_pend && r_row[r_pidx]) begin
                    n_mask = r_mask | ({{(MASK_W - 1){1'b0}}, 1'b1} << w_col_rdata);
                end
                if (r_idx < r_lim) begin
                    n_pend = 1'b1;
                    n_pidx = PIDX_W'(r_idx);
                    n_idx  = r_idx + 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_state = S_PICK;
                    end
                end
            end
            S_PICK: begin
                w_col_we    = 1'b1;
                w_col_waddr = r_depth;
                w_col_wdata = w_pick_ok ? w_pick_color : '0;
                if (w_pick_ok) begin
                    if (r_depth == CW'(VERTICES - 1)) begin
                        n_cnt   = '0;
                        n_state = S_OREAD;
                    end else begin
                        n_depth = r_depth + 1'b1;
                        n_state = S_VISIT;
                    end
                end else if (r_depth == '0) begin
                    n_out.found        = 1'b0;
                    n_out.vertex_id    = '0;
                    n_out.vertex_color = '0;
                    n_out.last         = 1'b1;
                    n_out_valid        = 1'b1;
                    n_state            = S_OHOLD;
                end else begin
                    n_depth = r_depth - 1'b1;
                    n_state = S_VISIT;
                end
            end
            S_OREAD: begin
                w_col_raddr = r_cnt;
                n_state     = S_OWAIT;
            end
            S_OWAIT: begin
                n_out.found        = 1'b1;
                n_out.vertex_id    = ID_W'(r_cnt);
                n_out.vertex_color = w_col_rdata;
                n_out.last         = (r_cnt == CW'(REPORTED - 1));
                n_out_valid        = 1'b1;
                n_state            = S_OHOLD;
            end
            S_OHOLD: begin
                if (i_out_ready) begin
                    n_out_valid = 1'b0;
                    if (r_out.last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_cnt   = r_cnt + 1'b1;
                        n_state = S_OREAD;
                    end
                end
            end
            default: begin
                n_state     = S_IDLE;
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_num_colors <= NUM_COLORS_RST;
            r_adj_vld    <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_num_colors <= i_cfg_wdata;
            end
            if (w_in_fire && w_row_in_range) begin
                r_adj_vld[w_adj_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt    <= n_cnt;
        r_depth  <= n_depth;
        r_row_ok <= n_row_ok;
        r_row    <= n_row;
        r_cur    <= n_cur;
        r_mask   <= n_mask;
        r_lim    <= n_lim;
        r_idx    <= n_idx;
        r_pend   <= n_pend;
        r_pidx   <= n_pidx;
        r_out    <= n_out;
    end

    `GMC_ASSERT_NXT(a_last_ends_run, i_clk, i_rst_n,
        o_out_valid && i_out_ready && o_out_data.last, r_state == S_IDLE,
        "run did not end after last result")
    `GMC_ASSERT_NOW(a_fail_is_last, i_clk, i_rst_n,
        o_out_valid && !o_out_data.found, o_out_data.last,
        "failure result without last")
    `GMC_ASSERT_NOW(a_no_in_while_out, i_clk, i_rst_n,
        o_out_valid, !o_in_ready,
        "input taken while result pending")
    `GMC_ASSERT_NXT(a_backtrack, i_clk, i_rst_n,
        r_state == S_PICK && !w_pick_ok && r_depth != '0,
        r_state == S_VISIT && r_depth == $past(r_depth) - 1'b1,
        "backtrack step lost")

endmodule
